FILE: design/sorted_table_binary_search_assert.svh
// Assertion macros for the sorted table search block.
// Each macro samples on clk and is disabled while rst is high; the using module supplies both.
`ifndef SORTED_TABLE_BINARY_SEARCH_ASSERT_SVH
`define SORTED_TABLE_BINARY_SEARCH_ASSERT_SVH
`ifndef SYNTHESIS
`define STBS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define STBS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define STBS_ASSERT_NOW(lbl, ante, cons, msg)
`define STBS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

FILE: design/stbs_pkg.sv
// Shared constants, types and command/status structures for the sorted table search block.
// No dependencies; used by stbs_ctrl, stbs_dpath and the top level.
`default_nettype none
package stbs_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = IDX_W + 1;
  localparam int PTR_W       = CNT_W + 1;
  localparam int DATA_W      = 32;

  localparam logic signed [PTR_W-1:0] PTR_ONE = PTR_W'(1);

  // Input selector codes carried on tuser.
  localparam logic FUNC_LOAD   = 1'b0;
  localparam logic FUNC_SEARCH = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_PROBE,
    S_NB_FIRST,
    S_NB_SECOND,
    S_FINISH
  } stbs_state_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_WRITE,
    OP_INIT,
    OP_FIRST,
    OP_STEP,
    OP_MATCH,
    OP_NB_LOWER,
    OP_NB_UPPER
  } stbs_op_t;

  typedef struct packed {
    stbs_op_t op;
    logic     load_out;
  } stbs_cmd_t;

  typedef struct packed {
    logic empty;
    logic match;
    logic open_next;
    logic out_free;
  } stbs_status_t;

  typedef struct packed {
    logic                     found;
    logic [IDX_W-1:0]         position;
    logic                     has_lower;
    logic signed [DATA_W-1:0] lower_value;
    logic                     has_upper;
    logic signed [DATA_W-1:0] upper_value;
  } stbs_result_t;

endpackage
`default_nettype wire

FILE: design/sorted_table_binary_search.sv
// Sorted table binary search: a 1024-entry table of signed 32-bit values, loaded one entry per
// transfer, and searched for a target. A load transfer (tuser 0) writes the entry at its slot in
// the cycle it is accepted and gives no result. A search transfer (tuser 1) probes the middle of
// the remaining range of the first table_count entries (saturated at 1024), one memory read per
// probe, and answers either with found and the matching slot or with the nearest smaller and
// nearest larger entries and their valid flags. An empty table answers with everything clear.
// A search sets up the bounds on acceptance, issues the first read, probes (at most 11 probes
// for a full table), makes two neighbour reads when the target is absent, and then registers
// the result; an empty table skips the probes. A result that cannot yet enter the output
// register, because the previous one has not been taken, holds the search in its finish state.
// The block takes one item at a time; the input is ready again as soon as the result sits in
// the output register, even if the downstream side has not yet taken it. table_count is written
// through cfg_we and cfg_wdata; the user must write it only while no search is in flight, which
// the block itself does not enforce. Entries must be loaded before a search can reach them; an
// unloaded slot reads as an undefined value.
`default_nettype none
module sorted_table_binary_search (
  input  wire         clk,
  input  wire         rst,
  // Configuration: table_count.
  input  wire         cfg_we,
  input  wire  [10:0] cfg_wdata,
  // Input stream.
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [47:0] s_axis_tdata,   // [9:0] slot, [41:10] value, rest zero
  input  wire  [0:0]  s_axis_tuser,   // [0] func
  // Result stream.
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [79:0] m_axis_tdata,   // [9:0] position, [41:10] lower_value, [73:42] upper_value
  output logic [2:0]  m_axis_tuser    // [0] found, [1] has_lower, [2] has_upper
);
  import stbs_pkg::*;

  stbs_cmd_t    cmd;
  stbs_status_t status;
  stbs_result_t result;

  logic [IDX_W-1:0]         in_slot;
  logic signed [DATA_W-1:0] in_value;

  // Unpack the input transfer: slot sits in the low bits, the value directly above it.
  assign in_slot  = s_axis_tdata[IDX_W-1:0];
  assign in_value = $signed(s_axis_tdata[IDX_W+DATA_W-1:IDX_W]);

  stbs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_func  (s_axis_tuser[0]),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  stbs_dpath u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_slot    (in_slot),
    .in_value   (in_value),
    .cmd        (cmd),
    .status     (status),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_result (result)
  );

  // Pack the result: the three flags travel on tuser, the slot and both neighbours on tdata,
  // with the unused top bits held at zero.
  assign m_axis_tuser = {result.has_upper, result.has_lower, result.found};
  assign m_axis_tdata = {6'b0, result.upper_value, result.lower_value, result.position};

endmodule
`default_nettype wire

FILE: design/stbs_ctrl.sv
// Sequencing state machine for the sorted table search block.
// Depends on stbs_pkg; drives stbs_dpath through a command struct and reads its status.
`default_nettype none
module stbs_ctrl (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   in_valid,
  input  wire                   in_func,
  output logic                  in_ready,
  input  stbs_pkg::stbs_status_t status,
  output stbs_pkg::stbs_cmd_t   cmd
);
  import stbs_pkg::*;

`include "sorted_table_binary_search_assert.svh"

  stbs_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid && in_func == FUNC_SEARCH) state_next = S_START;
      end
      S_START: begin
        state_next = status.empty ? S_FINISH : S_PROBE;
      end
      S_PROBE: begin
        if (status.match) state_next = S_FINISH;
        else if (!status.open_next) state_next = S_NB_FIRST;
      end
      S_NB_FIRST:  state_next = S_NB_SECOND;
      S_NB_SECOND: state_next = S_FINISH;
      S_FINISH: begin
        if (status.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready     = 1'b0;
    cmd.op       = OP_NONE;
    cmd.load_out = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) cmd.op = (in_func == FUNC_SEARCH) ? OP_INIT : OP_WRITE;
      end
      S_START: begin
        if (!status.empty) cmd.op = OP_FIRST;
      end
      S_PROBE: begin
        cmd.op = status.match ? OP_MATCH : OP_STEP;
      end
      S_NB_FIRST:  cmd.op = OP_NB_LOWER;
      S_NB_SECOND: cmd.op = OP_NB_UPPER;
      S_FINISH: begin
        cmd.load_out = status.out_free;
      end
      default: cmd.op = OP_NONE;
    endcase
  end

  `STBS_ASSERT_NEXT(a_match_ends, state == S_PROBE && status.match, state == S_FINISH, "match did not end the search")
  `STBS_ASSERT_NEXT(a_nb_pair, state == S_NB_FIRST, state == S_NB_SECOND, "neighbour reads out of order")
  `STBS_ASSERT_NEXT(a_finish_hold, state == S_FINISH && !status.out_free, state == S_FINISH, "result dropped while output busy")

endmodule
`default_nettype wire

FILE: design/stbs_dpath.sv
// Datapath for the sorted table search block: entry memory, search bounds, result registers.
// Depends on stbs_pkg; controlled by stbs_ctrl through command and status structs.
`default_nettype none
module stbs_dpath (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               cfg_we,
  input  wire  [stbs_pkg::CNT_W-1:0]        cfg_wdata,
  input  wire  [stbs_pkg::IDX_W-1:0]        in_slot,
  input  wire  signed [stbs_pkg::DATA_W-1:0] in_value,
  input  stbs_pkg::stbs_cmd_t               cmd,
  output stbs_pkg::stbs_status_t            status,
  output logic                              out_valid,
  input  wire                               out_ready,
  output stbs_pkg::stbs_result_t            out_result
);
  import stbs_pkg::*;

`include "sorted_table_binary_search_assert.svh"

  logic [DATA_W-1:0]        mem [TABLE_DEPTH];
  logic [DATA_W-1:0]        rdata;
  logic [IDX_W-1:0]         raddr;

  logic [CNT_W-1:0]         table_count;
  logic [CNT_W-1:0]         n;
  logic [CNT_W-1:0]         n_sat;
  logic signed [DATA_W-1:0] target;
  logic signed [PTR_W-1:0]  lo, hi;
  logic [IDX_W-1:0]         mid;
  stbs_result_t             work;

  logic signed [PTR_W-1:0]  sum_cur, sum_next, mid_ext, lo_next, hi_next;
  logic [IDX_W-1:0]         mid_cur, mid_next;
  logic                     greater;

  assign n_sat = (table_count > CNT_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH) : table_count;

  assign sum_cur = lo + hi;
  assign mid_cur = sum_cur[IDX_W:1];
  assign mid_ext = $signed({{(PTR_W-IDX_W){1'b0}}, mid});

  assign greater  = $signed(rdata) > target;
  assign lo_next  = greater ? lo : mid_ext + PTR_ONE;
  assign hi_next  = greater ? mid_ext - PTR_ONE : hi;
  assign sum_next = lo_next + hi_next;
  assign mid_next = sum_next[IDX_W:1];

  assign status.empty     = lo > hi;
  assign status.match     = $signed(rdata) == target;
  assign status.open_next = lo_next <= hi_next;
  assign status.out_free  = !out_valid || out_ready;

  always_comb begin
    raddr = mid_cur;
    case (cmd.op)
      OP_STEP:     raddr = status.open_next ? mid_next : hi_next[IDX_W-1:0];
      OP_NB_LOWER: raddr = lo[IDX_W-1:0];
      default:     raddr = mid_cur;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_WRITE) begin
      mem[in_slot] <= in_value;
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      table_count <= '0;
    end else if (cfg_we) begin
      table_count <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_INIT: begin
        target <= in_value;
        n      <= n_sat;
        lo     <= '0;
        hi     <= $signed({1'b0, n_sat}) - PTR_ONE;
        work   <= '0;
      end
      OP_FIRST: begin
        mid <= mid_cur;
      end
      OP_STEP: begin
        lo <= lo_next;
        hi <= hi_next;
        if (status.open_next) mid <= mid_next;
        work.has_lower <= !status.open_next && !hi_next[PTR_W-1];
        work.has_upper <= !status.open_next && (lo_next < $signed({1'b0, n}));
      end
      OP_MATCH: begin
        work.found    <= 1'b1;
        work.position <= mid;
      end
      OP_NB_LOWER: begin
        work.lower_value <= work.has_lower ? $signed(rdata) : '0;
      end
      OP_NB_UPPER: begin
        work.upper_value <= work.has_upper ? $signed(rdata) : '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_result <= work;
    end
  end

  `STBS_ASSERT_NEXT(a_out_loaded, cmd.load_out, out_valid, "result not presented after load")
  `STBS_ASSERT_NOW(a_found_clean, out_valid && out_result.found, !out_result.has_lower && !out_result.has_upper, "found result carries neighbours")
  `STBS_ASSERT_NOW(a_step_open, cmd.op == OP_STEP, lo <= hi && !lo[PTR_W-1], "probe outside the open range")
  `STBS_ASSERT_NEXT(a_exit_adjacent, cmd.op == OP_STEP && !status.open_next, lo == hi + PTR_ONE, "search ended with bounds not adjacent")

endmodule
`default_nettype wire

FILE: bench/search_result_checker.sv
`timescale 1ns / 1ps
// Result checker for the sorted table search block: mirrors the table and table_count from the
// input and configuration transfers, predicts each search answer and compares the result stream.
// Depends on stbs_pkg for the result layout, the table depth and the selector codes.
module search_result_checker (
  input  wire         clk,
  input  wire         rst,
  input  wire         cfg_we,
  input  wire  [10:0] cfg_wdata,
  input  wire         s_axis_tvalid,
  input  wire         s_axis_tready,
  input  wire  [47:0] s_axis_tdata,
  input  wire  [0:0]  s_axis_tuser,
  input  wire         m_axis_tvalid,
  input  wire         m_axis_tready,
  input  wire  [79:0] m_axis_tdata,
  input  wire  [2:0]  m_axis_tuser,
  output int          mismatches,
  output int          outstanding
);
  import stbs_pkg::*;

  localparam int REPORT_LIMIT = 10;

  logic signed [DATA_W-1:0] entry_image [TABLE_DEPTH];
  logic [CNT_W-1:0]         covered_count;
  stbs_result_t             expected_answers [$];

  // Same probe order as the block: middle of [left, right], stop on a match. A miss reports
  // the entry at right below the target and the entry at left above it.
  function automatic stbs_result_t predict_answer(input logic signed [DATA_W-1:0] target);
    int           span;
    int           left;
    int           right;
    int           probe;
    bit           hit;
    stbs_result_t answer;
    answer = '0;
    span   = (covered_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(covered_count);
    left   = 0;
    right  = span - 1;
    probe  = 0;
    hit    = 1'b0;
    while (!hit && left <= right) begin
      probe = (left + right) / 2;
      if (entry_image[probe] == target) begin
        hit = 1'b1;
      end else if (entry_image[probe] > target) begin
        right = probe - 1;
      end else begin
        left = probe + 1;
      end
    end
    if (hit) begin
      answer.found    = 1'b1;
      answer.position = probe[IDX_W-1:0];
    end else if (span > 0) begin
      if (left >= span) begin
        answer.has_lower   = 1'b1;
        answer.lower_value = entry_image[span-1];
      end else if (right < 0) begin
        answer.has_upper   = 1'b1;
        answer.upper_value = entry_image[0];
      end else begin
        answer.has_lower   = 1'b1;
        answer.lower_value = entry_image[right];
        answer.has_upper   = 1'b1;
        answer.upper_value = entry_image[left];
      end
    end
    return answer;
  endfunction

  task automatic report(input string why, input stbs_result_t want, input stbs_result_t got);
    if (mismatches < REPORT_LIMIT) begin
      $display("%0t: %s", $realtime, why);
      $display("  expected found=%0d position=%0d lower=%0d/%0d upper=%0d/%0d",
               want.found, want.position, want.has_lower, want.lower_value,
               want.has_upper, want.upper_value);
      $display("  actual   found=%0d position=%0d lower=%0d/%0d upper=%0d/%0d",
               got.found, got.position, got.has_lower, got.lower_value,
               got.has_upper, got.upper_value);
    end
    mismatches++;
  endtask

  always @(posedge clk) begin
    stbs_result_t got;
    if (rst) begin
      covered_count = '0;
      expected_answers.delete();
    end else begin
      // A result leaving now belongs to an earlier search, so it is matched before any new
      // search accepted at the same edge is queued.
      if (m_axis_tvalid && m_axis_tready) begin
        got.found       = m_axis_tuser[0];
        got.has_lower   = m_axis_tuser[1];
        got.has_upper   = m_axis_tuser[2];
        got.position    = m_axis_tdata[9:0];
        got.lower_value = m_axis_tdata[41:10];
        got.upper_value = m_axis_tdata[73:42];
        if (expected_answers.size() == 0) begin
          report("result transfer with no search outstanding", '0, got);
        end else if (got !== expected_answers[0]) begin
          report("search result differs", expected_answers.pop_front(), got);
        end else begin
          void'(expected_answers.pop_front());
        end
      end
      if (cfg_we) begin
        covered_count = cfg_wdata;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser[0] == FUNC_LOAD) begin
          entry_image[s_axis_tdata[9:0]] = s_axis_tdata[41:10];
        end else begin
          expected_answers.insert(expected_answers.size(),
                                  predict_answer(s_axis_tdata[41:10]));
        end
      end
    end
    outstanding = expected_answers.size();
  end

endmodule

FILE: bench/sorted_table_binary_search_tb.sv
`timescale 1ns / 1ps
// Top of the sorted table search bench: clock, reset, stimulus, result back-pressure and verdict.
// Depends on stbs_pkg, the sorted_table_binary_search block and search_result_checker.
module sorted_table_binary_search_tb;
  import stbs_pkg::*;

  // Quiet time after the last answer, ample to let the block go idle before table_count is
  // rewritten or the run ends.
  localparam int DRAIN_CYCLES = 20;
  // Longest honest silence: a sender gap, a search, a receiver stall, plus the drain before a
  // register write. The watchdog allows many times that.
  localparam int STALL_LIMIT  = 2000;
  // Input transfers sent over the whole run, table loads included.
  localparam int TOTAL_ITEMS  = 1500;

  logic         clk;
  logic         rst;
  logic         cfg_we;
  logic [10:0]  cfg_wdata;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [47:0]  s_axis_tdata;   // [9:0] slot, [41:10] value, rest zero
  logic [0:0]   s_axis_tuser;   // [0] func
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [79:0]  m_axis_tdata;   // [9:0] position, [41:10] lower_value, [73:42] upper_value
  logic [2:0]   m_axis_tuser;   // [0] found, [1] has_lower, [2] has_upper

  int mismatches;
  int outstanding;
  int items_sent;
  int quiet_cycles;

  // Mirror of what has been loaded, used only to aim search targets at real entries.
  logic signed [DATA_W-1:0] entry_shadow [TABLE_DEPTH];
  bit sender_eager;
  bit receiver_eager;

  sorted_table_binary_search dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  search_result_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .mismatches    (mismatches),
    .outstanding   (outstanding)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // One input transfer. The task is entered at a falling edge and leaves at the falling edge
  // after the transfer, so valid stays high across back-to-back items when no gap is drawn.
  task automatic send_item(input logic func, input logic [IDX_W-1:0] slot,
                           input logic signed [DATA_W-1:0] value);
    int gap;
    gap = sender_eager ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= func;
    s_axis_tdata  <= {6'b0, value, slot};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    if (func == FUNC_LOAD) begin
      entry_shadow[slot] = value;
    end
    items_sent++;
    @(negedge clk);
  endtask

  // table_count may only change while the block is idle: every search answered, and then the
  // drain so that nothing is still in flight inside the block.
  task automatic set_count(input int count);
    s_axis_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= count[10:0];
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Loads slots 0 to span-1 with a non-decreasing sequence, either densely packed (so that
  // duplicates and neighbours one apart are common) or spread over the whole signed range.
  // The slots are written in a rotated order so the table is only sorted once all are in.
  task automatic fill_sorted(input int span);
    logic signed [DATA_W-1:0] sorted_vals [TABLE_DEPTH];
    longint stride;
    longint room;
    longint level;
    int     start;
    int     k;
    if (span == 0) return;
    stride = ($urandom_range(0, 1) == 0) ? 64'sd4 : 64'sd4294967296 / (span + 1);
    room   = 64'sd4294967296 - span * stride;
    level  = (longint'($urandom) % room) - 64'sd2147483648;
    for (k = 0; k < span; k++) begin
      sorted_vals[k] = level[DATA_W-1:0];
      level += longint'($urandom) % stride;
    end
    start = $urandom_range(0, span - 1);
    for (k = 0; k < span; k++) begin
      send_item(FUNC_LOAD, IDX_W'((start + k) % span), sorted_vals[(start + k) % span]);
    end
  endtask

  // Mostly entries that are present, or one off them, or just outside the ends of the covered
  // range; the rest are arbitrary 32-bit targets.
  function automatic logic signed [DATA_W-1:0] pick_target(input int span);
    int unsigned dice;
    int          k;
    dice = $urandom_range(0, 7);
    if (span == 0 || dice >= 6) return $urandom;
    k = $urandom_range(0, span - 1);
    case (dice) inside
      [0:3]:   return entry_shadow[k];
      4:       return entry_shadow[k] + (($urandom_range(0, 1) == 0) ? 1 : -1);
      default: return ($urandom_range(0, 1) == 0) ? entry_shadow[0] - 1
                                                   : entry_shadow[span-1] + 1;
    endcase
  endfunction

  // One setting of table_count followed by a mix of searches and loads. Loads above the covered
  // range are harmless noise; a rare load inside it breaks the ordering on purpose.
  task automatic run_phase(input int count, input bit refill, input int n_items);
    int          span;
    int          k;
    int unsigned dice;
    span = (count > TABLE_DEPTH) ? TABLE_DEPTH : count;
    set_count(count);
    sender_eager = ($urandom_range(0, 3) == 0);
    if (refill) fill_sorted(span);
    for (k = 0; k < n_items; k++) begin
      dice = $urandom_range(0, 99);
      if (dice < 72 || (dice < 96 && span == TABLE_DEPTH) || (dice >= 96 && span == 0)) begin
        send_item(FUNC_SEARCH, IDX_W'($urandom), pick_target(span));
      end else if (dice < 96) begin
        send_item(FUNC_LOAD, IDX_W'($urandom_range(span, TABLE_DEPTH - 1)), $urandom);
      end else begin
        send_item(FUNC_LOAD, IDX_W'($urandom_range(0, span - 1)), $urandom);
      end
    end
  endtask

  // Result side: before each result it may hold tready low for a drawn number of cycles, and
  // now and then it switches between stalling and taking every result at once.
  initial begin
    int gap;
    m_axis_tready  = 1'b0;
    receiver_eager = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if ($urandom_range(0, 15) == 0) receiver_eager = !receiver_eager;
      gap = receiver_eager ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk);
      while (!(m_axis_tvalid && m_axis_tready)) @(posedge clk);
      @(negedge clk);
    end
  end

  // Watchdog: any transfer on either stream, or a register write, counts as progress.
  always @(posedge clk) begin
    if (rst || cfg_we || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int pick;
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = FUNC_LOAD;
    items_sent    = 0;
    sender_eager  = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part. table_count is zero out of reset, so the first searches see an empty table.
    send_item(FUNC_SEARCH, '0, 32'sd0);
    send_item(FUNC_SEARCH, '1, 32'sh8000_0000);
    send_item(FUNC_LOAD, 10'd0, -32'sd100);
    send_item(FUNC_LOAD, 10'd1, -32'sd5);
    send_item(FUNC_LOAD, 10'd2, 32'sd0);
    send_item(FUNC_LOAD, 10'd3, 32'sd7);
    send_item(FUNC_LOAD, 10'd4, 32'sh7FFF_FFFF);
    // The top slot with the most negative value lies beyond the covered range and is never read.
    send_item(FUNC_LOAD, 10'd1023, 32'sh8000_0000);
    set_count(5);
    send_item(FUNC_SEARCH, '0, 32'sh8000_0000);  // below every entry
    send_item(FUNC_SEARCH, '0, -32'sd100);       // match in the first slot
    send_item(FUNC_SEARCH, '0, -32'sd6);         // between the first two entries
    send_item(FUNC_SEARCH, '0, 32'sd0);          // match found on the first probe
    send_item(FUNC_SEARCH, '0, 32'sh7FFF_FFFF);  // match in the last slot
    send_item(FUNC_SEARCH, '0, 32'sh7FFF_FFFE);  // just under the largest entry
    send_item(FUNC_SEARCH, '0, 32'sd8);
    set_count(1);
    send_item(FUNC_SEARCH, '0, -32'sd100);
    send_item(FUNC_SEARCH, '0, -32'sd200);
    send_item(FUNC_SEARCH, '0, 32'sd50);
    set_count(4);
    send_item(FUNC_SEARCH, '0, 32'sh7FFF_FFFF);  // above every covered entry
    send_item(FUNC_SEARCH, '0, 32'sd7);

    // A full sorted table first, so every slot holds a loaded value from here on and any
    // table_count, including the saturating ones above the depth, stays within loaded data.
    run_phase(TABLE_DEPTH, 1'b1, 120);
    run_phase(2047, 1'b0, 60);
    run_phase(TABLE_DEPTH + 1, 1'b0, 20);

    // Random part, until the whole run has sent about TOTAL_ITEMS input transfers: mostly small
    // freshly sorted tables, with empty, single-entry and large settings mixed in over whatever
    // the earlier phases left behind.
    while (items_sent < TOTAL_ITEMS) begin
      pick = $urandom_range(0, 15);
      case (pick)
        0:       run_phase(0, 1'b0, $urandom_range(5, 20));
        1:       run_phase(1, 1'b1, $urandom_range(20, 60));
        2:       run_phase($urandom_range(TABLE_DEPTH + 1, 2047), 1'b0, $urandom_range(20, 60));
        3:       run_phase($urandom_range(49, TABLE_DEPTH), 1'b0, $urandom_range(20, 60));
        default: run_phase($urandom_range(2, 48), 1'b1, $urandom_range(20, 80));
      endcase
    end

    s_axis_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
